### design/sfv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_pkg
// Shared types and codes for the scanf format validator.
// ----------------------------------------------------------------------------
package sfv_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned WidthW = 24;
  localparam int unsigned FieldW = WidthW + 1;

  localparam logic [WidthW-1:0] WidthLimit = 24'hFFFFFF;
  localparam logic [CountW-1:0] MaxConvReset = 8'd8;

  // result kinds
  localparam logic [1:0] KIND_REC  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // conversion types
  localparam logic TYPE_INT = 1'b0;
  localparam logic TYPE_STR = 1'b1;

  // format characters
  localparam logic [ChW-1:0] CH_NUL     = 8'h00;
  localparam logic [ChW-1:0] CH_PCT     = 8'h25; // %
  localparam logic [ChW-1:0] CH_STAR    = 8'h2A; // *
  localparam logic [ChW-1:0] CH_ZERO    = 8'h30;
  localparam logic [ChW-1:0] CH_NINE    = 8'h39;
  localparam logic [ChW-1:0] CH_LBRACK  = 8'h5B; // [
  localparam logic [ChW-1:0] CH_RBRACK  = 8'h5D; // ]
  localparam logic [ChW-1:0] CH_CARET   = 8'h5E; // ^
  localparam logic [ChW-1:0] CH_LOWER_C = 8'h63;
  localparam logic [ChW-1:0] CH_LOWER_D = 8'h64;
  localparam logic [ChW-1:0] CH_LOWER_I = 8'h69;
  localparam logic [ChW-1:0] CH_LOWER_S = 8'h73;
  localparam logic [ChW-1:0] CH_LOWER_X = 8'h78;

  typedef enum logic [2:0] {
    PH_TEXT    = 3'd0,
    PH_PCT     = 3'd1,
    PH_WIDTH   = 3'd2,
    PH_BRACKET = 3'd3,
    PH_SWALLOW = 3'd4
  } phase_t;

  typedef struct packed {
    logic                     valid;
    logic [1:0]               kind;
    logic                     conv_type;
    logic signed [FieldW-1:0] field_width;
    logic [ChW-1:0]           spec_char;
    logic [CountW-1:0]        conv_count;
  } sfv_result_t;

endpackage
`default_nettype wire

### design/scanf_format_validator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scanf_format_validator
// Checks a scanf format string fed one byte per transfer and reports each
// recorded conversion, the final count or an error.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready, ch): one format byte per transfer, a zero
//     byte ends the string.
//   out channel (out_valid/out_ready, kind, conv_type, field_width,
//     spec_char, conv_count): at most one result per byte; bytes that cause
//     nothing produce no transfer.
//   cfg channel (cfg_valid/cfg_ready, cfg_data): writes max_conversions;
//     cfg_ready is always high. Write only while the block is idle.
//   Path: a byte is held in the input register while it is parsed, and its
//     result is loaded into the output register once the output register
//     is free or draining.
//   Throughput: one byte per cycle unless the output register stalls.
//   Stall: while out_valid is held low-ready, the input register keeps its
//     byte and in_ready drops once it is full.
//   Reset: parser returns to plain text with a zero count, both registers
//     empty, max_conversions back to 8.
// ----------------------------------------------------------------------------
module scanf_format_validator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sfv_pkg::CountW-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [sfv_pkg::ChW-1:0]           ch,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             kind,
  output logic                                   conv_type,
  output logic signed [sfv_pkg::FieldW-1:0]      field_width,
  output logic [sfv_pkg::ChW-1:0]                spec_char,
  output logic [sfv_pkg::CountW-1:0]             conv_count
);
  import sfv_pkg::*;

  logic              s1_valid;
  logic [ChW-1:0]    s1_ch;
  logic [CountW-1:0] max_conversions;
  logic              adv;
  sfv_result_t       result;

  assign cfg_ready = 1'b1;
  // parse the held byte when the output register is free or draining
  assign adv       = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_conversions <= MaxConvReset;
    end else if (cfg_valid && cfg_ready) begin
      max_conversions <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch <= ch;
    end
  end

  sfv_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (adv),
    .ch              (s1_ch),
    .max_conversions (max_conversions),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= result.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && result.valid) begin
      kind        <= result.kind;
      conv_type   <= result.conv_type;
      field_width <= result.field_width;
      spec_char   <= result.spec_char;
      conv_count  <= result.conv_count;
    end
  end

`ifndef SYNTHESIS
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_ch))
    else $error("input register lost its byte while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("registers not empty after reset");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_REC || kind == KIND_DONE || kind == KIND_ERR))
    else $error("undefined result kind");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERR |-> conv_count == '0 && field_width == '0
      && spec_char == '0 && conv_type == TYPE_INT)
    else $error("error result carries payload");
`endif

endmodule
`default_nettype wire

### design/sfv_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_parser
// Format parsing state machine: consumes one byte per step and produces at
// most one result.
// ----------------------------------------------------------------------------
module sfv_parser (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [sfv_pkg::ChW-1:0]    ch,
  input  wire logic [sfv_pkg::CountW-1:0] max_conversions,
  output sfv_pkg::sfv_result_t            result
);
  import sfv_pkg::*;

  phase_t              phase, phase_next;
  logic [WidthW-1:0]   width_value, width_value_next;
  logic                has_width, has_width_next;
  logic                suppressed, suppressed_next;
  logic                bracket_first, bracket_first_next;
  logic                swallow_close, swallow_close_next;
  logic [CountW-1:0]   record_count, record_count_next;

  // decode of the current byte
  logic                is_digit;
  logic [WidthW-1:0]   base;
  logic [WidthW+4:0]   width_sum;
  logic                width_ovf;
  logic                is_int;
  logic                is_str;

  // actions chosen by the phase decode
  logic                act_fail;
  logic                act_fin;
  logic                act_done;
  logic                fin_type;
  logic [ChW-1:0]      fin_spec;
  logic                fin_bad;
  logic                fail_all;
  logic                rec;

  // plain per-phase updates, overridden on fail, finish and end of string
  phase_t              ph_plain;
  logic [WidthW-1:0]   wv_plain;
  logic                hw_plain;
  logic                sup_plain;
  logic                bf_plain;
  logic                sc_plain;

  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign base      = has_width ? width_value : '0;
  // base * 10 + digit
  assign width_sum = {2'b00, base, 3'b000} + {4'b0000, base, 1'b0}
                   + {{(WidthW+1){1'b0}}, ch[3:0] & {4{is_digit}}};
  assign width_ovf = width_sum > {5'b00000, WidthLimit};
  assign is_int    = (ch == CH_LOWER_D) || (ch == CH_LOWER_I) || (ch == CH_LOWER_X);
  assign is_str    = (ch == CH_LOWER_S) || (ch == CH_LOWER_C);

  always_comb begin
    act_fail  = 1'b0;
    act_fin   = 1'b0;
    act_done  = 1'b0;
    fin_type  = TYPE_INT;
    fin_spec  = ch;
    ph_plain  = phase;
    wv_plain  = width_value;
    hw_plain  = has_width;
    sup_plain = suppressed;
    bf_plain  = bracket_first;
    sc_plain  = swallow_close;
    unique case (phase)
      PH_PCT, PH_WIDTH: begin
        if (phase == PH_PCT && ch == CH_PCT) begin
          ph_plain = PH_TEXT;
        end else if (phase == PH_PCT && ch == CH_STAR) begin
          sup_plain = 1'b1;
          ph_plain  = PH_WIDTH;
        end else if (is_digit) begin
          if (width_ovf) begin
            act_fail = 1'b1;
          end else begin
            wv_plain = width_sum[WidthW-1:0];
            hw_plain = 1'b1;
            ph_plain = PH_WIDTH;
          end
        end else if (ch == CH_LBRACK) begin
          ph_plain = PH_BRACKET;
          bf_plain = 1'b1;
          sc_plain = 1'b1;
        end else if (is_int) begin
          act_fin  = 1'b1;
          fin_type = TYPE_INT;
        end else if (is_str) begin
          act_fin  = 1'b1;
          fin_type = TYPE_STR;
        end else begin
          // terminator or unknown specifier
          act_fail = 1'b1;
        end
      end
      PH_BRACKET: begin
        if (ch == CH_NUL) begin
          act_fail = 1'b1;
        end else if (ch == CH_RBRACK && !swallow_close) begin
          act_fin  = 1'b1;
          fin_type = TYPE_STR;
          fin_spec = CH_LBRACK;
        end else begin
          sc_plain = bracket_first && (ch == CH_CARET);
          bf_plain = 1'b0;
        end
      end
      PH_SWALLOW: begin
        if (ch == CH_NUL) begin
          ph_plain = PH_TEXT;
        end
      end
      default: begin
        if (ch == CH_NUL) begin
          act_done = 1'b1;
          ph_plain = PH_TEXT;
        end else begin
          ph_plain = (ch == CH_PCT) ? PH_PCT : PH_TEXT;
        end
      end
    endcase
  end

  assign fin_bad  = act_fin && ((record_count == max_conversions)
                                || (!has_width && fin_type == TYPE_STR));
  assign fail_all = act_fail || fin_bad;
  assign rec      = act_fin && !fin_bad && !suppressed;

  // next state
  always_comb begin
    phase_next         = ph_plain;
    width_value_next   = wv_plain;
    has_width_next     = hw_plain;
    suppressed_next    = sup_plain;
    bracket_first_next = bf_plain;
    swallow_close_next = sc_plain;
    record_count_next  = record_count;
    if (fail_all || act_fin || act_done || (phase == PH_SWALLOW && ch == CH_NUL)) begin
      width_value_next   = '0;
      has_width_next     = 1'b0;
      suppressed_next    = 1'b0;
      bracket_first_next = 1'b0;
      swallow_close_next = 1'b0;
    end
    if (fail_all) begin
      phase_next = (ch == CH_NUL) ? PH_TEXT : PH_SWALLOW;
      if (ch == CH_NUL) begin
        record_count_next = '0;
      end
    end else if (act_fin) begin
      phase_next = PH_TEXT;
      if (rec) begin
        record_count_next = record_count + CountW'(1);
      end
    end else if (act_done || (phase == PH_SWALLOW && ch == CH_NUL)) begin
      record_count_next = '0;
    end
  end

  // result
  always_comb begin
    result = '0;
    if (fail_all) begin
      result.valid = 1'b1;
      result.kind  = KIND_ERR;
    end else if (rec) begin
      result.valid       = 1'b1;
      result.kind        = KIND_REC;
      result.conv_type   = fin_type;
      result.field_width = has_width ? $signed({1'b0, width_value}) : '1;
      result.spec_char   = fin_spec;
    end else if (act_done) begin
      result.valid      = 1'b1;
      result.kind       = KIND_DONE;
      result.conv_count = record_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TEXT;
      width_value   <= '0;
      has_width     <= 1'b0;
      suppressed    <= 1'b0;
      bracket_first <= 1'b0;
      swallow_close <= 1'b0;
      record_count  <= '0;
    end else if (step) begin
      phase         <= phase_next;
      width_value   <= width_value_next;
      has_width     <= has_width_next;
      suppressed    <= suppressed_next;
      bracket_first <= bracket_first_next;
      swallow_close <= swallow_close_next;
      record_count  <= record_count_next;
    end
  end

endmodule
`default_nettype wire

### bench/tb_scanf_format_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scanf_format_validator
// Streams scanf format strings into the validator one byte per transfer, a
// short fixed table first and then random strings under several
// max_conversions settings and flow-control patterns. A behavioral parser
// predicts every record, count and error except on the fixed rows, and
// each result is checked against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_scanf_format_validator;
  import sfv_pkg::*;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     conv_type;
    logic signed [FieldW-1:0] field_width;
    logic [ChW-1:0]           spec_char;
    logic [CountW-1:0]        conv_count;
  } conv_result_t;

  typedef struct packed {
    logic [ChW-1:0] b;
    logic           fixed;
    logic           has_res;
    conv_result_t   res;
  } format_row_t;

  localparam int NumRows       = 32;
  localparam int MaxReport     = 10;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseBytes    = 40;

  localparam conv_result_t NoResult = '0;

  // fixed rows carry a hand-written result, the rest follow the parser
  localparam format_row_t FormatRows [NumRows] = '{
    '{CH_NUL,     1'b1, 1'b1, '{KIND_DONE, TYPE_INT, 25'sd0, CH_NUL, 8'd0}},
    '{CH_PCT,     1'b0, 1'b0, NoResult},
    '{CH_PCT,     1'b0, 1'b0, NoResult},
    '{CH_PCT,     1'b0, 1'b0, NoResult},
    '{CH_LOWER_X, 1'b1, 1'b1, '{KIND_REC, TYPE_INT, -25'sd1, CH_LOWER_X, 8'd0}},
    '{CH_PCT,     1'b0, 1'b0, NoResult},
    '{8'h31,      1'b0, 1'b0, NoResult},
    '{8'h36,      1'b0, 1'b0, NoResult},
    '{8'h37,      1'b0, 1'b0, NoResult},
    '{8'h37,      1'b0, 1'b0, NoResult},
    '{8'h37,      1'b0, 1'b0, NoResult},
    '{8'h32,      1'b0, 1'b0, NoResult},
    '{8'h31,      1'b0, 1'b0, NoResult},
    '{8'h35,      1'b0, 1'b0, NoResult},
    '{CH_LBRACK,  1'b0, 1'b0, NoResult},
    '{CH_CARET,   1'b0, 1'b0, NoResult},
    '{CH_RBRACK,  1'b0, 1'b0, NoResult},
    '{8'h61,      1'b0, 1'b0, NoResult},
    '{CH_RBRACK,  1'b1, 1'b1, '{KIND_REC, TYPE_STR, 25'sd16777215, CH_LBRACK, 8'd0}},
    '{CH_PCT,     1'b0, 1'b0, NoResult},
    '{CH_STAR,    1'b0, 1'b0, NoResult},
    '{CH_LOWER_D, 1'b0, 1'b0, NoResult},
    '{CH_NUL,     1'b1, 1'b1, '{KIND_DONE, TYPE_INT, 25'sd0, CH_NUL, 8'd2}},
    '{CH_PCT,     1'b0, 1'b0, NoResult},
    '{8'h71,      1'b1, 1'b1, '{KIND_ERR, TYPE_INT, 25'sd0, CH_NUL, 8'd0}},
    '{CH_NUL,     1'b0, 1'b0, NoResult},
    '{CH_PCT,     1'b0, 1'b0, NoResult},
    '{CH_LOWER_S, 1'b1, 1'b1, '{KIND_ERR, TYPE_INT, 25'sd0, CH_NUL, 8'd0}},
    '{8'hFF,      1'b0, 1'b0, NoResult},
    '{CH_NUL,     1'b0, 1'b0, NoResult},
    '{CH_PCT,     1'b0, 1'b0, NoResult},
    '{CH_NUL,     1'b1, 1'b1, '{KIND_ERR, TYPE_INT, 25'sd0, CH_NUL, 8'd0}}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CountW-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [ChW-1:0]           ch = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               kind;
  logic                     conv_type;
  logic signed [FieldW-1:0] field_width;
  logic [ChW-1:0]           spec_char;
  logic [CountW-1:0]        conv_count;

  // parser shadow state
  logic [CountW-1:0] max_conv = MaxConvReset;
  phase_t            parse_phase = PH_TEXT;
  logic [WidthW-1:0] width_acc = '0;
  logic              width_seen = 1'b0;
  logic              star_seen = 1'b0;
  logic              class_first = 1'b0;
  logic              class_keep_close = 1'b0;
  logic [CountW-1:0] rec_count = '0;

  conv_result_t pending_results[$];
  conv_result_t seen_res;
  conv_result_t want_res;
  int           mismatches = 0;
  int           results_seen = 0;
  int           bytes_sent = 0;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           quiet_cycles = 0;

  always #6 clk = ~clk;

  scanf_format_validator u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .conv_type  (conv_type),
    .field_width(field_width),
    .spec_char  (spec_char),
    .conv_count (conv_count)
  );

  task automatic clear_spec();
    width_acc        = '0;
    width_seen       = 1'b0;
    star_seen        = 1'b0;
    class_first      = 1'b0;
    class_keep_close = 1'b0;
  endtask

  task automatic parse_byte(input logic [ChW-1:0] c, output bit got, output conv_result_t r);
    logic [31:0]    next_w;
    bit             conv_end;
    bit             bad;
    logic           ctype;
    logic [ChW-1:0] spec;
    got      = 1'b0;
    r        = '0;
    conv_end = 1'b0;
    bad      = 1'b0;
    ctype    = TYPE_INT;
    spec     = c;
    case (parse_phase)
      PH_PCT, PH_WIDTH: begin
        if (parse_phase == PH_PCT && c == CH_PCT) begin
          parse_phase = PH_TEXT;
        end else if (parse_phase == PH_PCT && c == CH_STAR) begin
          star_seen   = 1'b1;
          parse_phase = PH_WIDTH;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          next_w = (width_seen ? 32'(width_acc) : 32'd0) * 10 + 32'(c - CH_ZERO);
          if (next_w > 32'(WidthLimit)) begin
            bad = 1'b1;
          end else begin
            width_acc   = next_w[WidthW-1:0];
            width_seen  = 1'b1;
            parse_phase = PH_WIDTH;
          end
        end else if (c == CH_LBRACK) begin
          parse_phase      = PH_BRACKET;
          class_first      = 1'b1;
          class_keep_close = 1'b1;
        end else if (c == CH_LOWER_D || c == CH_LOWER_I || c == CH_LOWER_X) begin
          conv_end = 1'b1;
        end else if (c == CH_LOWER_S || c == CH_LOWER_C) begin
          conv_end = 1'b1;
          ctype    = TYPE_STR;
        end else begin
          bad = 1'b1;
        end
      end
      PH_BRACKET: begin
        if (c == CH_NUL) begin
          bad = 1'b1;
        end else if (c == CH_RBRACK && !class_keep_close) begin
          conv_end = 1'b1;
          ctype    = TYPE_STR;
          spec     = CH_LBRACK;
        end else begin
          // a ']' right after '[' or "[^" is a set member
          class_keep_close = class_first && (c == CH_CARET);
          class_first      = 1'b0;
        end
      end
      PH_SWALLOW: begin
        if (c == CH_NUL) begin
          parse_phase = PH_TEXT;
          rec_count   = '0;
          clear_spec();
        end
      end
      default: begin
        if (c == CH_NUL) begin
          got          = 1'b1;
          r.kind       = KIND_DONE;
          r.conv_count = rec_count;
          parse_phase  = PH_TEXT;
          rec_count    = '0;
          clear_spec();
        end else begin
          parse_phase = (c == CH_PCT) ? PH_PCT : PH_TEXT;
        end
      end
    endcase
    if (conv_end) begin
      // table-full check applies to suppressed conversions as well
      if (rec_count == max_conv || (!width_seen && ctype == TYPE_STR)) begin
        bad = 1'b1;
      end else begin
        if (!star_seen) begin
          got           = 1'b1;
          r.kind        = KIND_REC;
          r.conv_type   = ctype;
          r.field_width = width_seen ? $signed({1'b0, width_acc}) : -25'sd1;
          r.spec_char   = spec;
          rec_count     = rec_count + 8'd1;
        end
        clear_spec();
        parse_phase = PH_TEXT;
      end
    end
    if (bad) begin
      clear_spec();
      if (c == CH_NUL) begin
        parse_phase = PH_TEXT;
        rec_count   = '0;
      end else begin
        parse_phase = PH_SWALLOW;
      end
      got    = 1'b1;
      r      = '0;
      r.kind = KIND_ERR;
    end
  endtask

  task automatic send_byte(input logic [ChW-1:0] b, input bit fixed, input bit fix_has,
                           input conv_result_t fix_res);
    bit           got;
    conv_result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    parse_byte(b, got, r);
    if (fixed) begin
      got = fix_has;
      r   = fix_res;
    end
    if (got) pending_results.push_back(r);
  endtask

  // hold off the sender until every predicted result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_max(input logic [CountW-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_conv = v;
  endtask

  task automatic send_format_string();
    logic [ChW-1:0] fmt[$];
    logic [ChW-1:0] digit_buf[$];
    logic [ChW-1:0] b;
    logic [31:0]    w;
    int             parts;
    int             pick;
    bit             cut;
    cut = 1'b0;
    if ($urandom_range(9) == 0) begin
      // raw noise, no terminator appended
      repeat ($urandom_range(1, 12)) fmt.push_back(8'($urandom_range(255)));
      cut = 1'b1;
    end else begin
      parts = $urandom_range(0, 9);
      for (int i = 0; i < parts && !cut; i++) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          fmt.push_back(CH_PCT);
          if ($urandom_range(4) == 0) fmt.push_back(CH_STAR);
          pick = $urandom_range(19);
          if (pick >= 4) begin
            if (pick < 16) w = $urandom_range(999);
            else if (pick < 18) w = $urandom_range(32'hFFFFFF, 32'hFFFFF0);
            else w = $urandom_range(99999999, 32'h1000000);
            if ($urandom_range(7) == 0) fmt.push_back(CH_ZERO);
            do begin
              digit_buf.push_front(CH_ZERO + 8'(w % 10));
              w = w / 10;
            end while (w != 0);
            while (digit_buf.size() != 0) fmt.push_back(digit_buf.pop_front());
          end
          pick = $urandom_range(39);
          if (pick < 6) fmt.push_back(CH_LOWER_D);
          else if (pick < 10) fmt.push_back(CH_LOWER_I);
          else if (pick < 14) fmt.push_back(CH_LOWER_X);
          else if (pick < 20) fmt.push_back(CH_LOWER_S);
          else if (pick < 25) fmt.push_back(CH_LOWER_C);
          else if (pick < 34) begin
            fmt.push_back(CH_LBRACK);
            if ($urandom_range(1) == 0) fmt.push_back(CH_CARET);
            if ($urandom_range(2) == 0) fmt.push_back(CH_RBRACK);
            repeat ($urandom_range(0, 4)) begin
              b = 8'($urandom_range(1, 255));
              if (b == CH_RBRACK) b = CH_CARET;
              fmt.push_back(b);
            end
            if ($urandom_range(11) == 0) begin
              fmt.push_back(CH_NUL);
              cut = 1'b1;
            end else begin
              fmt.push_back(CH_RBRACK);
            end
          end
          else if (pick < 36) fmt.push_back(8'($urandom_range(255)));
          else if (pick < 37) fmt.push_back(CH_PCT);
          else if (pick < 38) fmt.push_back(CH_STAR);
          else begin
            // string ends inside the specifier
            fmt.push_back(CH_NUL);
            cut = 1'b1;
          end
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(1, 255));
            if (b == CH_PCT) b = CH_STAR;
            fmt.push_back(b);
          end
        end else if (pick < 93) begin
          fmt.push_back(CH_PCT);
          fmt.push_back(CH_PCT);
        end else begin
          fmt.push_back(CH_PCT);
          fmt.push_back(8'($urandom_range(255)));
        end
      end
    end
    if (!cut) fmt.push_back(CH_NUL);
    foreach (fmt[k]) send_byte(fmt[k], 1'b0, 1'b0, NoResult);
    if ($urandom_range(15) == 0) wait_drained();
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_res = '{kind, conv_type, field_width, spec_char, conv_count};
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < MaxReport)
          $display("result %0d unexpected: kind=%0d type=%0d width=%0d spec=%02h count=%0d",
                   results_seen, seen_res.kind, seen_res.conv_type, seen_res.field_width,
                   seen_res.spec_char, seen_res.conv_count);
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res !== want_res) begin
          if (mismatches < MaxReport) begin
            $write("result %0d: expected kind=%0d type=%0d width=%0d spec=%02h count=%0d,",
                   results_seen, want_res.kind, want_res.conv_type, want_res.field_width,
                   want_res.spec_char, want_res.conv_count);
            $display(" got kind=%0d type=%0d width=%0d spec=%02h count=%0d",
                     seen_res.kind, seen_res.conv_type, seen_res.field_width,
                     seen_res.spec_char, seen_res.conv_count);
          end
          mismatches++;
        end
      end
    end
  end

  // no transfer on any channel for too long means the block is hung
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("scanf_format_validator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                phase_start;
    logic [CountW-1:0] setting;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < NumRows; n++)
      send_byte(FormatRows[n].b, FormatRows[n].fixed, FormatRows[n].has_res, FormatRows[n].res);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 46;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 46;
        end
        default: begin
          send_idle  = 24;
          recv_stall = 24;
        end
      endcase
      case (p)
        0:       setting = max_conv;
        1:       setting = 8'd255;
        2:       setting = 8'd0;
        3:       setting = 8'd2;
        4:       setting = 8'd1;
        default: setting = 8'($urandom_range(3, 254));
      endcase
      if (p != 0) write_max(setting);
      if (setting == 8'd255) begin
        // fill the table to its top count, then close the string
        send_byte(CH_NUL, 1'b0, 1'b0, NoResult);
        repeat (255) begin
          send_byte(CH_PCT, 1'b0, 1'b0, NoResult);
          send_byte(CH_LOWER_D, 1'b0, 1'b0, NoResult);
        end
        send_byte(CH_NUL, 1'b0, 1'b0, NoResult);
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_format_string();
    end

    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("scanf_format_validator: match");
    end else begin
      $display("scanf_format_validator: mismatch");
    end
    $finish;
  end

endmodule
